@@ hdl/albd_pkg.sv @@
// ----------------------------------------------------------------------------
// albd_pkg
// shared types, constants and register map of the ladder button debouncer
// ----------------------------------------------------------------------------
package albd_pkg;

	// adc resolution actually used from each sample
	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned CODE_W      = 16;
	localparam int unsigned WIN_W       = CODE_W + 2;

	typedef logic [CODE_W-1:0]         code_t;
	typedef logic signed [WIN_W-1:0]   wcode_t;
	typedef logic [7:0]                ticks_t;
	typedef logic [1:0]                button_t;

	// register map
	typedef enum logic [2:0] {
		REG_IDLE_THR  = 3'd0,
		REG_TOLERANCE = 3'd1,
		REG_LVL_LEFT  = 3'd2,
		REG_LVL_UP    = 3'd3,
		REG_LVL_DOWN  = 3'd4,
		REG_LVL_RIGHT = 3'd5,
		REG_REL_TICKS = 3'd6
	} reg_idx_t;

	localparam code_t  RST_IDLE_THR  = 16'd64741;
	localparam code_t  RST_TOLERANCE = 16'd794;
	localparam code_t  RST_LVL_LEFT  = 16'd39718;
	localparam code_t  RST_LVL_UP    = 16'd10526;
	localparam code_t  RST_LVL_DOWN  = 16'd25022;
	localparam code_t  RST_LVL_RIGHT = 16'd60;
	localparam ticks_t RST_REL_TICKS = 8'd20;

	// debounce phase, one-hot
	typedef enum logic [2:0] {
		PH_OPEN   = 3'b001,
		PH_CLOSED = 3'b010,
		PH_BOUNCE = 3'b100
	} phase_t;

	// phase codes as reported on the result
	localparam logic [1:0] PCODE_OPEN   = 2'd0;
	localparam logic [1:0] PCODE_CLOSED = 2'd1;
	localparam logic [1:0] PCODE_BOUNCE = 2'd2;

	typedef struct packed {
		logic       held_valid;
		logic [1:0] phase;
		button_t    event_button;
		logic       press_event;
	} result_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] c;
		unique case (ph)
			PH_CLOSED: c = PCODE_CLOSED;
			PH_BOUNCE: c = PCODE_BOUNCE;
			default:   c = PCODE_OPEN;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/albd_window.sv @@
// ----------------------------------------------------------------------------
// albd_window
// acceptance window check: level - tol <= code <= level + tol, no wrap
// ----------------------------------------------------------------------------
module albd_window (
	input  albd_pkg::code_t code,
	input  albd_pkg::code_t level,
	input  albd_pkg::code_t tol,
	output logic            hit
);
	import albd_pkg::*;

	wcode_t code_w;
	wcode_t lo;
	wcode_t hi;

	// two extra bits keep the bounds exact in both directions
	assign code_w = wcode_t'({2'b00, code});
	assign lo     = wcode_t'({2'b00, level}) - wcode_t'({2'b00, tol});
	assign hi     = wcode_t'({2'b00, level}) + wcode_t'({2'b00, tol});
	assign hit    = (code_w >= lo) && (code_w <= hi);

endmodule

@@ hdl/analog_ladder_button_debouncer.sv @@
// ----------------------------------------------------------------------------
// analog_ladder_button_debouncer
// four-button resistor-ladder keypad decoder with press detection and debounce
// ----------------------------------------------------------------------------
// a sample is registered in code_s1, and its result in the result register when it advances
// throughput: one sample per cycle, sustained; output stalls back up at once
// the whole update runs combinationally between the sample and result registers
// reset: async, active low; config back to nominal levels, phase open,
//   no held button, countdown zero, both pipeline stages empty
// ----------------------------------------------------------------------------
module analog_ladder_button_debouncer (
	input  logic                    clk,
	input  logic                    arst_n,
	// sample request
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [15:0]             s_tdata,   // [15:0] sample
	// result request
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,   // [0] press_event, [2:1] event_button,
	                                           // [3] held_valid, [5:4] phase, [7:6] zero
	// configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  albd_pkg::code_t         cfg_data
);
	import albd_pkg::*;

	// configuration registers
	code_t  idle_thr_q;
	code_t  tol_q;
	code_t  lvl_q [4];
	ticks_t rel_ticks_q;

	// debounce state
	phase_t  phase_q;
	button_t held_btn_q;
	logic    held_flag_q;
	ticks_t  cd_q;

	// pipeline
	logic    valid_s1;
	code_t   code_s1;
	logic    out_valid_q;
	result_t out_q;

	// next-state logic
	logic    advance;
	logic    win_hit [4];
	logic    held_hit;
	logic    below_thr;
	logic    above_thr;
	ticks_t  cd_dec;
	phase_t  phase_d;
	button_t held_btn_d;
	logic    held_flag_d;
	ticks_t  cd_d;
	logic    press_d;
	button_t ev_btn_d;

	// ---------------- configuration ----------------
	// the user must write only while idle; the block does not enforce it, and writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_thr_q  <= RST_IDLE_THR;
			tol_q       <= RST_TOLERANCE;
			lvl_q[0]    <= RST_LVL_LEFT;
			lvl_q[1]    <= RST_LVL_UP;
			lvl_q[2]    <= RST_LVL_DOWN;
			lvl_q[3]    <= RST_LVL_RIGHT;
			rel_ticks_q <= RST_REL_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IDLE_THR:  idle_thr_q  <= cfg_data;
				REG_TOLERANCE: tol_q       <= cfg_data;
				REG_LVL_LEFT:  lvl_q[0]    <= cfg_data;
				REG_LVL_UP:    lvl_q[1]    <= cfg_data;
				REG_LVL_DOWN:  lvl_q[2]    <= cfg_data;
				REG_LVL_RIGHT: lvl_q[3]    <= cfg_data;
				REG_REL_TICKS: rel_ticks_q <= cfg_data[7:0];
				default: ;  // index past the map is dropped
			endcase
		end
	end

	// ---------------- handshake ----------------
	// stage 1 moves into the result register when that one is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// only the low SAMPLE_BITS of the sample carry the conversion
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= code_t'(s_tdata[SAMPLE_BITS-1:0]);
		end
	end

	// ---------------- window compares ----------------
	for (genvar b = 0; b < 4; b++) begin : g_win
		albd_window u_win (
			.code  (code_s1),
			.level (lvl_q[b]),
			.tol   (tol_q),
			.hit   (win_hit[b])
		);
	end

	// the held button's window is one of the four already computed
	assign held_hit  = win_hit[held_btn_q];
	assign below_thr = code_s1 < idle_thr_q;
	assign above_thr = code_s1 > idle_thr_q;

	// countdown drops first, in every phase
	assign cd_dec = (cd_q != '0) ? cd_q - 8'd1 : cd_q;

	// ---------------- debounce update ----------------
	always_comb begin
		phase_d     = phase_q;
		held_btn_d  = held_btn_q;
		held_flag_d = held_flag_q;
		cd_d        = cd_dec;
		press_d     = 1'b0;
		ev_btn_d    = '0;
		unique case (phase_q)
			PH_CLOSED: begin
				// release needs strictly above the threshold
				if (above_thr) begin
					phase_d = PH_BOUNCE;
					cd_d    = rel_ticks_q;
				end
			end
			PH_BOUNCE: begin
				if (held_hit) begin
					phase_d = PH_CLOSED;
				end
				// an expired countdown wins over a return to the window
				if (cd_dec == '0) begin
					phase_d     = PH_OPEN;
					held_flag_d = 1'b0;
					held_btn_d  = '0;
				end
			end
			default: begin
				phase_d = PH_OPEN;
				// left first, right last
				if (below_thr) begin
					if (win_hit[0] || win_hit[1] || win_hit[2] || win_hit[3]) begin
						phase_d     = PH_CLOSED;
						held_flag_d = 1'b1;
						press_d     = 1'b1;
						if (win_hit[0]) begin
							ev_btn_d = 2'd0;
						end else if (win_hit[1]) begin
							ev_btn_d = 2'd1;
						end else if (win_hit[2]) begin
							ev_btn_d = 2'd2;
						end else begin
							ev_btn_d = 2'd3;
						end
						held_btn_d = ev_btn_d;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			held_btn_q  <= '0;
			held_flag_q <= 1'b0;
			cd_q        <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			held_btn_q  <= held_btn_d;
			held_flag_q <= held_flag_d;
			cd_q        <= cd_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.press_event  <= press_d;
			out_q.event_button <= ev_btn_d;
			out_q.held_valid   <= held_flag_d;
			out_q.phase        <= phase_code(phase_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.phase, out_q.held_valid, out_q.event_button,
		out_q.press_event};

	// ---------------- checks ----------------
`ifndef SYNTHESIS
	// a button is latched exactly while not open
	a_flag_phase: assert property (@(posedge clk) disable iff (!arst_n)
		held_flag_q == (phase_q != PH_OPEN))
		else $error("held flag disagrees with phase");

	// open phase keeps the held button cleared
	a_open_btn: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OPEN) |-> (held_btn_q == '0))
		else $error("held button set while open");

	// entering bounce loads the release countdown
	a_bounce_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_CLOSED && phase_d == PH_BOUNCE)
		|=> (cd_q == $past(rel_ticks_q)))
		else $error("countdown not loaded on bounce entry");

	// a press result always reports a latched, closed button
	a_press_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[3] && m_tdata[5:4] == PCODE_CLOSED))
		else $error("press reported outside closed phase");
`endif

endmodule
